// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// Edge pulse counter package
// Shared constants, register indexes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package epc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = 3;
    localparam int COUNT_W  = 16;
    localparam int DIR_W    = 2;
    localparam int PERIOD_W = 16;
    localparam int LINK_W   = 3;
    localparam int CFG_W    = 24;
    localparam int INDEX_W  = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

    localparam logic [INDEX_W-1:0] REG_SNAPSHOT_PERIOD = 2'd0;
    localparam logic [INDEX_W-1:0] REG_LINK_ENABLE     = 2'd1;
    localparam logic [INDEX_W-1:0] REG_LINK_TARGETS    = 2'd2;

    localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
    localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;

    typedef struct packed {
        logic [COUNT_W-1:0]      count;
        logic signed [DIR_W-1:0] dir;
    } lane_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/epc_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one pin sample word per polling tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface epc_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] pin_sample;

    modport source (output valid, output pin_sample, input ready);
    modport sink   (input valid, input pin_sample, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/epc_out_if.sv =====
// ----------------------------------------------------------------------------
// Report channel
// Valid/ready channel carrying one channel word of a snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

interface epc_out_if;

    logic                       valid;
    logic                       ready;
    logic [epc_pkg::CH_W-1:0]    channel;
    logic [epc_pkg::COUNT_W-1:0] pulse_count;
    logic signed [epc_pkg::DIR_W-1:0] direction;
    logic                       last;

    modport source (output valid, output channel, output pulse_count,
                    output direction, output last, input ready);
    modport sink   (input valid, input channel, input pulse_count,
                    input direction, input last, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/epc_lane.sv =====
// ----------------------------------------------------------------------------
// Counter lane
// One channel: falling edge detect, wrapping pulse count and direction.
// ----------------------------------------------------------------------------
`default_nettype none

module epc_lane (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 pin,
    input  wire logic                 link_pin,
    input  wire logic                 link_en,
    output epc_pkg::lane_state_t      state
);

    logic                             prev_reg;
    logic [epc_pkg::COUNT_W-1:0]      count_reg;
    logic [epc_pkg::COUNT_W-1:0]      count_next;
    logic signed [epc_pkg::DIR_W-1:0] dir_reg;
    logic signed [epc_pkg::DIR_W-1:0] dir_next;
    logic                             fall;

    assign fall = prev_reg & ~pin;

    always_comb
    begin
        count_next = count_reg;
        dir_next   = dir_reg;
        if (fall)
        begin
            count_next = count_reg + epc_pkg::COUNT_W'(1);
            if (link_en)
            begin
                dir_next = link_pin ? epc_pkg::DIR_FWD : epc_pkg::DIR_REV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            count_reg <= '0;
            dir_reg   <= epc_pkg::DIR_NONE;
        end
        else if (advance)
        begin
            prev_reg  <= pin;
            count_reg <= count_next;
            dir_reg   <= dir_next;
        end
    end

    assign state.count = count_reg;
    assign state.dir   = dir_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/epc_snap.sv =====
// ----------------------------------------------------------------------------
// Snapshot merge
// Capture all lanes at once and send them out one channel word per cycle while the report channel is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module epc_snap (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        capture,
    input  wire epc_pkg::lane_state_t [epc_pkg::CHANNELS-1:0] lanes,
    output logic                                             free,
    epc_out_if.source                                        report
);

    epc_pkg::lane_state_t          buf_reg [epc_pkg::CHANNELS];
    logic [epc_pkg::CH_W-1:0]      idx_reg;
    logic [epc_pkg::CH_W-1:0]      idx_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          take;
    logic                          is_last;

    assign take    = report.valid && report.ready;
    assign is_last = (idx_reg == epc_pkg::CH_W'(epc_pkg::CHANNELS - 1));
    assign free    = !busy_reg || (take && is_last);

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (capture)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + epc_pkg::CH_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int i = 0; i < epc_pkg::CHANNELS; i++)
            begin
                buf_reg[i] <= lanes[i];
            end
        end
    end

    assign report.valid       = busy_reg;
    assign report.channel     = idx_reg;
    assign report.pulse_count = buf_reg[idx_reg].count;
    assign report.direction   = buf_reg[idx_reg].dir;
    assign report.last        = is_last;

    `ASSERT_ALWAYS(a_capture_free, !capture || free, "snapshot captured over pending words")
    `ASSERT_NEXT(a_capture_start, capture, report.valid && idx_reg == '0,
        "snapshot did not start at channel zero")
    `ASSERT_NEXT(a_hold_busy, take && !is_last, report.valid,
        "snapshot ended before last channel")
    `ASSERT_NEXT(a_end_idle, take && is_last && !capture, !report.valid,
        "word sent after last channel")

endmodule

`default_nettype wire

// ===== hw/rtl/edge_pulse_counter_with_direction.sv =====
// Snapshot words start in the cycle after the sample word that triggers the snapshot is accepted.
// Sample words are taken one per cycle, except that a snapshot tick waits
// until the previous snapshot drains its last word; a snapshot occupies the
// report channel for eight channel words, one per channel.
// Reset: counts, directions, previous pins and period counter clear to zero;
// snapshot period resets to 500, link enables and targets to zero.
// ----------------------------------------------------------------------------
// Edge pulse counter with direction
// Eight counter lanes with a snapshot merge stage and a period counter.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_pulse_counter_with_direction (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [epc_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [epc_pkg::CFG_W-1:0]     cfg_wdata,
    epc_in_if.sink                             sample,
    epc_out_if.source                          report
);

    logic [epc_pkg::PERIOD_W-1:0]                   period_reg;
    logic [epc_pkg::CHANNELS-1:0]                   link_en_reg;
    logic [epc_pkg::CHANNELS*epc_pkg::LINK_W-1:0]   targets_reg;
    logic [epc_pkg::PERIOD_W-1:0]                   tick_reg;
    logic [epc_pkg::PERIOD_W-1:0]                   tick_next;
    logic [epc_pkg::PERIOD_W:0]                     tick_inc;
    logic                                           accept;
    logic                                           snap_tick;
    logic                                           snap_free;
    epc_pkg::lane_state_t [epc_pkg::CHANNELS-1:0]   lanes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= epc_pkg::PERIOD_RESET;
            link_en_reg <= '0;
            targets_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                epc_pkg::REG_SNAPSHOT_PERIOD: period_reg  <= cfg_wdata[epc_pkg::PERIOD_W-1:0];
                epc_pkg::REG_LINK_ENABLE:     link_en_reg <= cfg_wdata[epc_pkg::CHANNELS-1:0];
                epc_pkg::REG_LINK_TARGETS:    targets_reg <= cfg_wdata;
                default:                      ;
            endcase
        end
    end

    assign snap_tick    = (tick_reg == '0);
    assign sample.ready = !snap_tick || snap_free;
    assign accept       = sample.valid && sample.ready;

    assign tick_inc  = {1'b0, tick_reg} + (epc_pkg::PERIOD_W + 1)'(1);
    assign tick_next = (tick_inc >= {1'b0, period_reg}) ? '0
                                                        : tick_inc[epc_pkg::PERIOD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
        end
        else if (accept)
        begin
            tick_reg <= tick_next;
        end
    end

    for (genvar i = 0; i < epc_pkg::CHANNELS; i++)
    begin : g_lane
        epc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (accept),
            .pin      (sample.pin_sample[i]),
            .link_pin (sample.pin_sample[targets_reg[i*epc_pkg::LINK_W +: epc_pkg::LINK_W]]),
            .link_en  (link_en_reg[i]),
            .state    (lanes[i])
        );
    end

    epc_snap u_snap (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (accept && snap_tick),
        .lanes   (lanes),
        .free    (snap_free),
        .report  (report)
    );

endmodule

`default_nettype wire
